/* hdl/ssmd_pkg.sv */
// shared types, register codes and reset values for the sensor smoothing block
`default_nettype none

package ssmd_pkg;

	// default widths
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int TIME_BITS_DEF   = 32;

	// register and port widths
	localparam int THR_W = 12;
	localparam int MS_W  = 16;
	localparam int CFG_W = 16;
	localparam int IDX_W = 3;

	// register indexes on the configuration port
	typedef enum logic [IDX_W-1:0] {
		REG_MARK_THR  = 3'd0,
		REG_MARK_LOW  = 3'd1,
		REG_OBS_THR   = 3'd2,
		REG_DEBOUNCE  = 3'd3,
		REG_REARM     = 3'd4
	} reg_idx_t;

	// request codes of an input word
	typedef enum logic {
		REQ_SAMPLE  = 1'b0,
		REQ_CONSUME = 1'b1
	} req_t;

	// configuration register set
	typedef struct packed {
		logic [THR_W-1:0] mark_threshold;
		logic             mark_active_low;
		logic [THR_W-1:0] obstacle_threshold;
		logic [MS_W-1:0]  debounce_ms;
		logic [MS_W-1:0]  rearm_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		mark_threshold:     12'd2048,
		mark_active_low:    1'b1,
		obstacle_threshold: 12'd2048,
		debounce_ms:        16'd20,
		rearm_ms:           16'd500
	};

	// per-word control from the top level to the merge stage
	typedef struct packed {
		logic sample;
		logic consume;
	} item_ctl_t;

endpackage

`default_nettype wire

/* hdl/ssmd_lane.sv */
// one filter lane: 3/4 old plus 1/4 new smoothing and threshold compare
`default_nettype none

module ssmd_lane #(
	parameter int SAMPLE_BITS = ssmd_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         update,
	input  wire logic [SAMPLE_BITS-1:0]       raw,
	input  wire logic [ssmd_pkg::THR_W-1:0]   threshold,
	output logic      [SAMPLE_BITS-1:0]       value,
	output logic                              at_or_above
);

	localparam int SumW = SAMPLE_BITS + 2;
	localparam int CmpW = (SAMPLE_BITS > ssmd_pkg::THR_W) ? SAMPLE_BITS : ssmd_pkg::THR_W;

	logic [SAMPLE_BITS-1:0] filt_q;
	logic [SAMPLE_BITS-1:0] filt_next;
	logic [SumW-1:0]        sum;

	// old * 3 + raw, then divide by four
	assign sum = {2'b00, filt_q} + {1'b0, filt_q, 1'b0} + {2'b00, raw};
	assign filt_next = (filt_q == '0) ? raw : sum[SumW-1:2];

	// value seen by this word: updated on a sample, held otherwise
	assign value = update ? filt_next : filt_q;
	assign at_or_above = CmpW'(value) >= CmpW'(threshold);

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
		end else if (update) begin
			filt_q <= filt_next;
		end
	end

endmodule

`default_nettype wire

/* hdl/ssmd_debounce.sv */
// merge stage: mark detection, hold-time debounce, re-arm and edge latch
`default_nettype none

module ssmd_debounce #(
	parameter int SAMPLE_BITS = ssmd_pkg::SAMPLE_BITS_DEF,
	parameter int TIME_BITS   = ssmd_pkg::TIME_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire ssmd_pkg::item_ctl_t     ctl,
	input  wire ssmd_pkg::cfg_t          cfg,
	input  wire logic [TIME_BITS-1:0]    now_ms,
	input  wire logic [SAMPLE_BITS-1:0]  mark_value,
	input  wire logic                    mark_ge,
	output logic                         present,
	output logic                         taken
);

	localparam int CmpW = (SAMPLE_BITS > ssmd_pkg::THR_W) ? SAMPLE_BITS : ssmd_pkg::THR_W;

	logic                 cand_q;
	logic [TIME_BITS-1:0] cand_start_q;
	logic                 stable_q;
	logic [TIME_BITS-1:0] last_edge_q;
	logic                 latch_q;

	logic                 det;
	logic                 cand_change;
	logic [TIME_BITS-1:0] held_time;
	logic [TIME_BITS-1:0] since_edge;
	logic                 held;
	logic                 go;
	logic                 rise;
	logic                 stable_next;

	// detection with selectable polarity
	always_comb begin
		if (cfg.mark_active_low) begin
			det = !mark_ge;
		end else begin
			det = mark_ge && (CmpW'(mark_value) != CmpW'(cfg.mark_threshold));
		end
	end

	// hold time and re-arm interval, modulo the timestamp width
	assign cand_change = (det != cand_q);
	assign held_time   = now_ms - cand_start_q;
	assign since_edge  = now_ms - last_edge_q;
	assign held = cand_change ? (cfg.debounce_ms == '0)
	                          : (held_time >= TIME_BITS'(cfg.debounce_ms));
	assign go          = held && (stable_q != det);
	assign rise        = go && det && (since_edge >= TIME_BITS'(cfg.rearm_ms));
	assign stable_next = go ? det : stable_q;

	// result bits
	assign present = ctl.sample ? stable_next : stable_q;
	assign taken   = ctl.consume ? latch_q : 1'b0;

	// debounce state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q       <= 1'b0;
			cand_start_q <= '0;
			stable_q     <= 1'b0;
			last_edge_q  <= '0;
			latch_q      <= 1'b0;
		end else if (ctl.sample) begin
			cand_q   <= det;
			stable_q <= stable_next;
			if (cand_change) begin
				cand_start_q <= now_ms;
			end
			if (rise) begin
				latch_q     <= 1'b1;
				last_edge_q <= now_ms;
			end
		end else if (ctl.consume) begin
			latch_q <= 1'b0;
		end
	end

	// a consume word always leaves the latch clear
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.consume |=> !latch_q)
		else $error("edge latch not cleared by consume word");

	// the stable level moves only on a sample word
	assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.sample |=> $stable(stable_q))
		else $error("stable level changed without a sample word");

	// a newly set latch comes with a high stable level and the edge time recorded
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.sample && rise |=> latch_q && stable_q && (last_edge_q == $past(now_ms)))
		else $error("latched edge without stable level or edge time");

	// the latch never sets on a consume word
	assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.sample && !latch_q |=> !latch_q)
		else $error("edge latch set without a sample word");

endmodule

`default_nettype wire

/* hdl/sensor_smoothing_and_mark_debounce.sv */
// top level: four filter lanes, mark debounce merge stage and a two-word output buffer
//
//  channel  signals                                   direction  handshake
//  in       req_type raw_mark *_raw now_ms             input      in_valid / in_ready
//  out      smooth_* *_obstacle mark_present edge_taken output    out_valid / out_ready
//  cfg      cfg_index cfg_data                        input      cfg_we, no wait
//
// one word per cycle while in_ready is high: lanes, debounce and edge latch all settle in the
// cycle a word is taken, and its result is written into the output buffer as the word is taken
// a two-word output buffer lets words be taken while the output stalls; in_ready falls
// only when both words wait
// reset clears filters, debounce state, latch, buffer and restores register defaults
`default_nettype none

module sensor_smoothing_and_mark_debounce #(
	parameter int SAMPLE_BITS = ssmd_pkg::SAMPLE_BITS_DEF,
	parameter int TIME_BITS   = ssmd_pkg::TIME_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          cfg_we,
	input  wire logic [ssmd_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [ssmd_pkg::CFG_W-1:0]    cfg_data,
	// input words
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          req_type,
	input  wire logic [SAMPLE_BITS-1:0]        raw_mark,
	input  wire logic [SAMPLE_BITS-1:0]        front_raw,
	input  wire logic [SAMPLE_BITS-1:0]        left_raw,
	input  wire logic [SAMPLE_BITS-1:0]        right_raw,
	input  wire logic [TIME_BITS-1:0]          now_ms,
	// result words
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [SAMPLE_BITS-1:0]        smooth_mark,
	output logic      [SAMPLE_BITS-1:0]        smooth_front,
	output logic      [SAMPLE_BITS-1:0]        smooth_left,
	output logic      [SAMPLE_BITS-1:0]        smooth_right,
	output logic                               front_obstacle,
	output logic                               left_obstacle,
	output logic                               right_obstacle,
	output logic                               mark_present,
	output logic                               edge_taken
);

	localparam int ResW = 4 * SAMPLE_BITS + 5;

	ssmd_pkg::cfg_t      cfg_q;
	ssmd_pkg::item_ctl_t ctl;

	logic                   push;
	logic                   pop;
	logic [SAMPLE_BITS-1:0] mark_v;
	logic [SAMPLE_BITS-1:0] front_v;
	logic [SAMPLE_BITS-1:0] left_v;
	logic [SAMPLE_BITS-1:0] right_v;
	logic                   mark_ge;
	logic                   front_ge;
	logic                   left_ge;
	logic                   right_ge;
	logic                   present;
	logic                   taken;
	logic [ResW-1:0]        res_d;
	logic [ResW-1:0]        res_rd;

	logic [ResW-1:0]        slot_q [2];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             cnt_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ssmd_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (ssmd_pkg::reg_idx_t'(cfg_index))
				ssmd_pkg::REG_MARK_THR: begin
					cfg_q.mark_threshold <= cfg_data[ssmd_pkg::THR_W-1:0];
				end
				ssmd_pkg::REG_MARK_LOW: begin
					cfg_q.mark_active_low <= cfg_data[0];
				end
				ssmd_pkg::REG_OBS_THR: begin
					cfg_q.obstacle_threshold <= cfg_data[ssmd_pkg::THR_W-1:0];
				end
				ssmd_pkg::REG_DEBOUNCE: begin
					cfg_q.debounce_ms <= cfg_data[ssmd_pkg::MS_W-1:0];
				end
				ssmd_pkg::REG_REARM: begin
					cfg_q.rearm_ms <= cfg_data[ssmd_pkg::MS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// word handshake and decode
	assign in_ready    = !cnt_q[1];
	assign out_valid   = (cnt_q != 2'd0);
	assign push        = in_valid && in_ready;
	assign pop         = out_valid && out_ready;
	assign ctl.sample  = push && (req_type == ssmd_pkg::REQ_SAMPLE);
	assign ctl.consume = push && (req_type == ssmd_pkg::REQ_CONSUME);

	// filter lanes
	ssmd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_mark (
		.clk(clk), .arst_n(arst_n), .update(ctl.sample), .raw(raw_mark),
		.threshold(cfg_q.mark_threshold), .value(mark_v), .at_or_above(mark_ge)
	);
	ssmd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_front (
		.clk(clk), .arst_n(arst_n), .update(ctl.sample), .raw(front_raw),
		.threshold(cfg_q.obstacle_threshold), .value(front_v), .at_or_above(front_ge)
	);
	ssmd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_left (
		.clk(clk), .arst_n(arst_n), .update(ctl.sample), .raw(left_raw),
		.threshold(cfg_q.obstacle_threshold), .value(left_v), .at_or_above(left_ge)
	);
	ssmd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_right (
		.clk(clk), .arst_n(arst_n), .update(ctl.sample), .raw(right_raw),
		.threshold(cfg_q.obstacle_threshold), .value(right_v), .at_or_above(right_ge)
	);

	// merge stage on the mark lane
	ssmd_debounce #(.SAMPLE_BITS(SAMPLE_BITS), .TIME_BITS(TIME_BITS)) u_debounce (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .cfg(cfg_q), .now_ms(now_ms),
		.mark_value(mark_v), .mark_ge(mark_ge), .present(present), .taken(taken)
	);

	// result word
	assign res_d = {mark_v, front_v, left_v, right_v,
	                front_ge, left_ge, right_ge, present, taken};

	// two-word output buffer, payload
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= res_d;
		end
	end

	// two-word output buffer, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// output unpack
	assign res_rd         = slot_q[rd_ptr_q];
	assign smooth_mark    = res_rd[4*SAMPLE_BITS+4:3*SAMPLE_BITS+5];
	assign smooth_front   = res_rd[3*SAMPLE_BITS+4:2*SAMPLE_BITS+5];
	assign smooth_left    = res_rd[2*SAMPLE_BITS+4:SAMPLE_BITS+5];
	assign smooth_right   = res_rd[SAMPLE_BITS+4:5];
	assign front_obstacle = res_rd[4];
	assign left_obstacle  = res_rd[3];
	assign right_obstacle = res_rd[2];
	assign mark_present   = res_rd[1];
	assign edge_taken     = res_rd[0];

endmodule

`default_nettype wire
